// File: hw/rtl/smzs_pkg.sv
// shared types and constants of the scaled matrix multiply block
package smzs_pkg;

  localparam int unsigned MatrixDimDefault = 64;
  localparam int unsigned MaxSide          = 64;
  localparam int unsigned AccW             = 38;
  localparam int unsigned ProdW            = 22;
  localparam logic [15:0] ScaleReset       = 16'd21845;

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_J_RUN,
    ST_DRAIN,
    ST_OUT_RUN,
    ST_OUT_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  row_index;
    logic [5:0]  col_index;
    logic [15:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [5:0]       out_row;
    logic [5:0]       out_col;
    logic [ProdW-1:0] product_value;
    logic             row_last;
  } res_t;

endpackage

// File: hw/rtl/scaled_matmul_zero_skip.sv
// scaled square matrix multiply, row at a time, skipping zero entries of A
// a load beat is absorbed in its accept cycle, busy stays low
// a compute beat keeps busy high through A_RD and A_CHK for each zero A entry, and
// also through J_RUN and DRAIN for each nonzero one, then through readout, the column
// passes set by the single read port of B and acc; results follow one per cycle
// reset clears control and the scale register to one third, stores stay undefined
module scaled_matmul_zero_skip #(
  parameter int unsigned MATRIX_DIM = smzs_pkg::MatrixDimDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  smzs_pkg::req_t  req_i,
  output logic            busy_o,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  output logic            res_valid_o,
  output smzs_pkg::res_t  res_o
);

  localparam int unsigned Side  = (MATRIX_DIM > smzs_pkg::MaxSide) ? smzs_pkg::MaxSide
                                                                  : MATRIX_DIM;
  localparam int unsigned IdxW  = (Side > 1) ? $clog2(Side) : 1;
  localparam int unsigned Depth = 1 << (2 * IdxW);
  localparam int unsigned AccW  = smzs_pkg::AccW;
  localparam int unsigned ProdW = smzs_pkg::ProdW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Side - 1);

  smzs_pkg::state_e state_q, state_d;

  logic [15:0]       scale_q;
  logic [IdxW-1:0]   row_q;
  logic [IdxW-1:0]   k_q;
  logic [IdxW-1:0]   j_q;
  logic [15:0]       scaled_q;
  logic              acc_live_q;

  logic [15:0]       a_mem [Depth];
  logic [15:0]       b_mem [Depth];
  logic [AccW-1:0]   acc_mem [Side];
  logic [15:0]       a_rdata_q;
  logic [15:0]       b_rdata_q;
  logic [AccW-1:0]   acc_rdata_q;

  logic              s1_vld_q, s2_vld_q;
  logic [IdxW-1:0]   s1_j_q, s2_j_q;
  logic [31:0]       mac_prod_q;
  logic [AccW-1:0]   s2_acc_q;

  logic              o1_vld_q;
  logic [IdxW-1:0]   o1_j_q;
  logic              res_vld_q;
  smzs_pkg::res_t    res_q;

  logic              accept;
  logic              load_ok;
  logic              row_ok;
  logic              j_iss;
  logic              o_iss;
  logic              pipe_empty;
  logic [31:0]       scale_mult;
  logic [AccW-1:0]   acc_sum;
  logic [AccW-1:0]   acc_eff;
  logic [AccW:0]     round_sum;
  logic [ProdW:0]    round_val;

  assign accept     = start_i && !busy_o;
  assign row_ok     = {1'b0, req_i.row_index} < 7'(Side);
  assign load_ok    = row_ok && ({1'b0, req_i.col_index} < 7'(Side));
  assign pipe_empty = !s1_vld_q && !s2_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      smzs_pkg::ST_IDLE: begin
        if (accept && req_i.req_type == smzs_pkg::REQ_COMPUTE && row_ok) begin
          state_d = smzs_pkg::ST_A_RD;
        end
      end
      smzs_pkg::ST_A_RD: state_d = smzs_pkg::ST_A_CHK;
      smzs_pkg::ST_A_CHK: begin
        if (a_rdata_q != '0) begin
          state_d = smzs_pkg::ST_J_RUN;
        end else if (k_q == LastIdx) begin
          state_d = smzs_pkg::ST_OUT_RUN;
        end else begin
          state_d = smzs_pkg::ST_A_RD;
        end
      end
      smzs_pkg::ST_J_RUN: begin
        if (j_q == LastIdx) begin
          state_d = smzs_pkg::ST_DRAIN;
        end
      end
      smzs_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = (k_q == LastIdx) ? smzs_pkg::ST_OUT_RUN : smzs_pkg::ST_A_RD;
        end
      end
      smzs_pkg::ST_OUT_RUN: begin
        if (j_q == LastIdx) begin
          state_d = smzs_pkg::ST_OUT_DRAIN;
        end
      end
      smzs_pkg::ST_OUT_DRAIN: state_d = smzs_pkg::ST_IDLE;
      default: state_d = smzs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy_o = 1'b1;
    j_iss  = 1'b0;
    o_iss  = 1'b0;
    case (state_q)
      smzs_pkg::ST_IDLE:    busy_o = 1'b0;
      smzs_pkg::ST_J_RUN:   j_iss  = 1'b1;
      smzs_pkg::ST_OUT_RUN: o_iss  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= smzs_pkg::ST_IDLE;
      scale_q    <= smzs_pkg::ScaleReset;
      acc_live_q <= 1'b0;
      k_q        <= '0;
      j_q        <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      o1_vld_q   <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= j_iss;
      s2_vld_q <= s1_vld_q;
      o1_vld_q <= o_iss;
      res_vld_q <= o1_vld_q;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
      if (state_q == smzs_pkg::ST_J_RUN || state_q == smzs_pkg::ST_OUT_RUN) begin
        j_q <= j_q + 1'b1;
      end else begin
        j_q <= '0;
      end
      case (state_q)
        smzs_pkg::ST_IDLE: begin
          k_q        <= '0;
          acc_live_q <= 1'b0;
        end
        smzs_pkg::ST_A_CHK: begin
          if (a_rdata_q == '0 && k_q != LastIdx) begin
            k_q <= k_q + 1'b1;
          end
        end
        smzs_pkg::ST_DRAIN: begin
          if (pipe_empty) begin
            acc_live_q <= 1'b1;
            if (k_q != LastIdx) begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  assign scale_mult = scale_q * a_rdata_q + 32'd32768;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= req_i.row_index[IdxW-1:0];
    end
    if (state_q == smzs_pkg::ST_A_CHK) begin
      scaled_q <= scale_mult[31:16];
    end
    s1_j_q     <= j_q;
    s2_j_q     <= s1_j_q;
    mac_prod_q <= scaled_q * b_rdata_q;
    s2_acc_q   <= acc_eff;
    o1_j_q     <= j_q;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (accept && load_ok && req_i.req_type == smzs_pkg::REQ_LOAD_A) begin
      a_mem[{req_i.row_index[IdxW-1:0], req_i.col_index[IdxW-1:0]}] <= req_i.entry_value;
    end
    a_rdata_q <= a_mem[{row_q, k_q}];
  end

  always_ff @(posedge clk_i) begin
    if (accept && load_ok && req_i.req_type == smzs_pkg::REQ_LOAD_B) begin
      b_mem[{req_i.row_index[IdxW-1:0], req_i.col_index[IdxW-1:0]}] <= req_i.entry_value;
    end
    b_rdata_q <= b_mem[{k_q, j_q}];
  end

  assign acc_eff = acc_live_q ? acc_rdata_q : '0;
  assign acc_sum = s2_acc_q + AccW'(mac_prod_q);

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      acc_mem[s2_j_q] <= acc_sum;
    end
    acc_rdata_q <= acc_mem[j_q];
  end

  // rounding and saturation of the readout
  assign round_sum = {1'b0, acc_eff} + (AccW + 1)'(32768);
  assign round_val = round_sum[AccW:16];

  always_ff @(posedge clk_i) begin
    res_q.out_row       <= 6'(row_q);
    res_q.out_col       <= 6'(o1_j_q);
    res_q.product_value <= round_val[ProdW] ? '1 : round_val[ProdW-1:0];
    res_q.row_last      <= (o1_j_q == LastIdx);
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_drained_before_a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smzs_pkg::ST_A_RD |-> !s1_vld_q && !s2_vld_q)
    else $error("accumulate pipeline busy at next A read");

  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.row_last |=> !res_valid_o)
    else $error("beat after row end");

  a_cols_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.row_last |=>
      res_valid_o && res_o.out_col == 6'($past(res_o.out_col) + 6'd1))
    else $error("row beats not in column order");

  a_compute_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.req_type == smzs_pkg::REQ_COMPUTE && row_ok |=> busy_o)
    else $error("compute beat did not start");

  a_no_mac_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smzs_pkg::ST_IDLE |-> !s1_vld_q && !s2_vld_q && !j_iss)
    else $error("accumulator write while idle");
`endif

endmodule
